### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Needs a clock named aclk and an active-low synchronous reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, switched off while reset is held
`define WHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included
`define WHP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/core/whp_pkg.sv
// Package for the WAVE header parser: parse phases, status codes, chunk tags.
// No dependencies.
package whp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_CHUNK  = 3'd2,
        PH_FMT    = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_NOT_PCM   = 3'd3,
        ST_SHORT_FMT = 3'd4
    } status_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM     = 16'd1;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    // Result word layout
    localparam int unsigned RES_BITS  = 3 + 32 + 16 + 16 + 32 + 32;
    localparam int unsigned TDATA_W   = ((RES_BITS + 7) / 8) * 8;
    localparam int unsigned PAD_BITS  = TDATA_W - RES_BITS;

endpackage

### rtl/core/wav_header_parser.sv
// WAVE header parser: byte in, at most one result per file, at the data chunk header or on an error.
// Latency: a result is registered on m_tdata in the cycle after the byte that causes it.
// Throughput: one byte per cycle while not held off; each byte updates the state registers on its transfer.
// Input is held off only while a result waits with m_tready low.
// Reset (aresetn low, synchronous) clears the phase to idle and the output to empty;
// after reset bytes are ignored until one arrives flagged as the first of a file.
`include "assert_macros.svh"

module wav_header_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    // byte stream in
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    input  logic                        s_tuser,   // first_byte
    input  logic                        s_tlast,   // last_byte
    // result out
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [2:0] status, [34:3] rate_hz, [50:35] sample_bits,
    // [66:51] channels, [98:67] data_start, [130:99] data_len, rest zero
    output logic [whp_pkg::TDATA_W-1:0] m_tdata
);
    import whp_pkg::*;

    // State registers
    phase_t        phase_reg, phase_next;
    logic [31:0]   pos_reg, pos_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [31:0]   tag_reg, tag_next;
    logic [31:0]   len_reg, len_next;
    logic [32:0]   skip_reg, skip_next;
    logic          fmt_seen_reg, fmt_seen_next;
    logic [15:0]   fmt_code_reg, fmt_code_next;
    logic [15:0]   chans_reg, chans_next;
    logic [31:0]   rate_reg, rate_next;
    logic [15:0]   bps_reg, bps_next;

    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;

    // Current view of the state, with a first byte restarting the parse
    phase_t        cur_phase;
    logic [31:0]   cur_pos;
    logic [3:0]    cur_cnt;
    logic [31:0]   cur_tag;
    logic [31:0]   cur_len;
    logic          cur_fmt_seen;

    logic          in_xfer;
    logic          res_fire;
    status_t       res_status;
    logic          res_data;
    logic          hdr_done;
    logic          hdr_bad;
    logic          chk_done;
    logic          fmt_done;
    logic [32:0]   skip_dec;
    logic [7:0]    b;
    logic [RES_BITS-1:0] res_word;
    logic          byte_dropped;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign b        = s_tdata;

    assign cur_phase    = s_tuser ? PH_HEADER : phase_reg;
    assign cur_pos      = s_tuser ? 32'd0 : pos_reg;
    assign cur_cnt      = s_tuser ? 4'd0  : cnt_reg;
    assign cur_tag      = s_tuser ? 32'd0 : tag_reg;
    assign cur_len      = s_tuser ? 32'd0 : len_reg;
    assign cur_fmt_seen = s_tuser ? 1'b0  : fmt_seen_reg;

    // Datapath: field assembly, counters and result
    always_comb begin
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        fmt_seen_next = fmt_seen_reg;
        fmt_code_next = fmt_code_reg;
        chans_next    = chans_reg;
        rate_next     = rate_reg;
        bps_next      = bps_reg;
        hdr_done      = 1'b0;
        hdr_bad       = 1'b0;
        chk_done      = 1'b0;
        fmt_done      = 1'b0;
        res_fire      = 1'b0;
        res_data      = 1'b0;
        res_status    = ST_OK;
        skip_dec      = skip_reg;

        if (s_tuser) begin
            pos_next      = 32'd0;
            cnt_next      = 4'd0;
            tag_next      = 32'd0;
            len_next      = 32'd0;
            skip_next     = 33'd0;
            fmt_seen_next = 1'b0;
        end

        if (cur_phase != PH_IDLE && cur_phase != PH_DONE) begin
            pos_next = cur_pos + 32'd1;
            unique case (cur_phase)
                PH_HEADER: begin
                    tag_next = {cur_tag[23:0], b};
                    if (cur_cnt == 4'd3 && tag_next != TAG_RIFF) begin
                        len_next = 32'd1;
                    end
                    if (cur_cnt >= 4'd11) begin
                        hdr_done = 1'b1;
                        hdr_bad  = (len_next != 32'd0) || (tag_next != TAG_WAVE);
                        cnt_next = 4'd0;
                        if (hdr_bad) begin
                            res_fire   = 1'b1;
                            res_status = ST_BAD_MAGIC;
                        end
                    end else begin
                        cnt_next = cur_cnt + 4'd1;
                    end
                end
                PH_CHUNK: begin
                    if (cur_cnt < 4'd4) begin
                        tag_next = {cur_tag[23:0], b};
                    end else begin
                        len_next = {b, cur_len[31:8]};
                    end
                    if (cur_cnt >= 4'd7) begin
                        chk_done = 1'b1;
                        cnt_next = 4'd0;
                        if (tag_next == TAG_DATA) begin
                            res_fire   = 1'b1;
                            res_data   = 1'b1;
                            res_status = (cur_fmt_seen && fmt_code_reg == FMT_PCM) ?
                                         ST_OK : ST_NOT_PCM;
                        end else if (tag_next == TAG_FMT) begin
                            if (len_next < FMT_MIN_LEN) begin
                                res_fire   = 1'b1;
                                res_status = ST_SHORT_FMT;
                            end else begin
                                skip_next = {1'b0, len_next} - {1'b0, FMT_MIN_LEN}
                                          + {32'd0, len_next[0]};
                            end
                        end else begin
                            skip_next = {1'b0, len_next} + {32'd0, len_next[0]};
                        end
                    end else begin
                        cnt_next = cur_cnt + 4'd1;
                    end
                end
                PH_FMT: begin
                    // keep format code, channels, rate and bits per sample bytes
                    unique case (cur_cnt)
                        4'd0:    fmt_code_next[7:0]  = b;
                        4'd1:    fmt_code_next[15:8] = b;
                        4'd2:    chans_next[7:0]     = b;
                        4'd3:    chans_next[15:8]    = b;
                        4'd4:    rate_next[7:0]      = b;
                        4'd5:    rate_next[15:8]     = b;
                        4'd6:    rate_next[23:16]    = b;
                        4'd7:    rate_next[31:24]    = b;
                        4'd14:   bps_next[7:0]       = b;
                        4'd15:   bps_next[15:8]      = b;
                        default: ;
                    endcase
                    if (cur_cnt == 4'd15) begin
                        fmt_done      = 1'b1;
                        fmt_seen_next = 1'b1;
                        cnt_next      = 4'd0;
                    end else begin
                        cnt_next = cur_cnt + 4'd1;
                    end
                end
                PH_SKIP: begin
                    if (skip_reg != 33'd0) begin
                        skip_dec = skip_reg - 33'd1;
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 33'd0) begin
                        cnt_next = 4'd0;
                    end
                end
                default: ;
            endcase

            if (!res_fire && s_tlast) begin
                res_fire   = 1'b1;
                res_status = ST_TRUNC;
            end
        end
    end

    // Next phase
    always_comb begin
        phase_next = s_tuser ? PH_HEADER : phase_reg;
        priority if (cur_phase == PH_IDLE || cur_phase == PH_DONE) begin
            phase_next = cur_phase;
        end else if (res_fire) begin
            phase_next = PH_DONE;
        end else begin
            unique case (cur_phase)
                PH_HEADER: if (hdr_done) begin
                    phase_next = PH_CHUNK;
                end
                PH_CHUNK: if (chk_done) begin
                    if (tag_next == TAG_FMT) begin
                        phase_next = PH_FMT;
                    end else if (skip_next != 33'd0) begin
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_CHUNK;
                    end
                end
                PH_FMT: if (fmt_done) begin
                    phase_next = (skip_reg != 33'd0) ? PH_SKIP : PH_CHUNK;
                end
                PH_SKIP: if (skip_dec == 33'd0) begin
                    phase_next = PH_CHUNK;
                end
                default: phase_next = cur_phase;
            endcase
        end
    end

    // Result word; fields from fmt only when the data header was reached
    always_comb begin
        res_word = '0;
        res_word[2:0] = res_status;
        if (res_data) begin
            if (cur_fmt_seen) begin
                res_word[34:3]  = rate_reg;
                res_word[50:35] = bps_reg;
                res_word[66:51] = chans_reg;
            end
            res_word[98:67]  = pos_next;
            res_word[130:99] = len_next;
        end
    end

    // Parse state, updated on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= 32'd0;
            cnt_reg      <= 4'd0;
            tag_reg      <= 32'd0;
            len_reg      <= 32'd0;
            skip_reg     <= 33'd0;
            fmt_seen_reg <= 1'b0;
        end else if (in_xfer) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            tag_reg      <= tag_next;
            len_reg      <= len_next;
            skip_reg     <= skip_next;
            fmt_seen_reg <= fmt_seen_next;
        end
    end

    // fmt fields: payload only
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            fmt_code_reg <= fmt_code_next;
            chans_reg    <= chans_next;
            rate_reg     <= rate_next;
            bps_reg      <= bps_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_xfer && res_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && res_fire) begin
            m_tdata_reg <= {{PAD_BITS{1'b0}}, res_word};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    assign byte_dropped = in_xfer && !s_tuser && (phase_reg == PH_IDLE || phase_reg == PH_DONE);

    `WHP_ASSERT(a_result_ends_parse, $rose(m_tvalid_reg) |-> phase_reg == PH_DONE, "early result")
    `WHP_ASSERT(a_idle_ignores, byte_dropped |=> $stable(pos_reg), "byte counted while idle")
    `WHP_ASSERT(a_skip_nonzero, phase_reg == PH_SKIP |-> skip_reg != 33'd0, "empty skip")
    `WHP_ASSERT(a_chunk_count, phase_reg == PH_CHUNK |-> cnt_reg <= 4'd7, "chunk count range")

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench for wav_header_parser: streams synthetic WAVE files one byte per transfer
// and checks each header result against a parser model kept in step with the input.
// Depends on whp_pkg and the wav_header_parser RTL.
module tb;
    import whp_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_MAX   = 2000;
    localparam int LONG_STALL     = 200;
    localparam int TAIL_CYCLES    = 16;
    localparam int RANDOM_BYTES   = 240;

    // kinds of generated file
    localparam int WAV_GOOD      = 0;
    localparam int WAV_NO_FMT    = 1;
    localparam int WAV_SHORT_FMT = 2;

    // chunk ids the parser must skip over
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [15:0] channels;
        logic [31:0] data_start;
        logic [31:0] data_len;
    } wav_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;  // [7:0] data_byte
    logic                s_tuser  = 1'b0;   // first_byte
    logic                s_tlast  = 1'b0;   // last_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [2:0] status, [34:3] rate_hz, [50:35] sample_bits,
    // [66:51] channels, [98:67] data_start, [130:99] data_len
    logic [TDATA_W-1:0]  m_tdata;

    wav_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // Parser model state
    phase_t      parse_ph  = PH_IDLE;
    logic [31:0] pos       = '0;
    logic [3:0]  fcnt      = '0;
    logic [31:0] tag       = '0;
    logic [31:0] clen      = '0;
    logic [32:0] skip_left = '0;
    logic [63:0] fmt_lo    = '0;
    logic [63:0] fmt_hi    = '0;
    logic        fmt_ok    = 1'b0;

    wav_result_t pending_results[$];
    logic [7:0]  file_bytes[$];
    int          parsed_bytes      = 0;
    int          n_errors          = 0;
    int          quiet_cycles      = 0;
    bit          tx_idle_on        = 1'b1;
    bit          rx_idle_on        = 1'b1;
    int          rx_gap            = 0;
    int          rx_hold           = 0;
    int          stall_req         = 0;
    int          stall_ack         = 0;

    // Advance the header parse by one byte; queue the result it causes, if any
    task automatic track_header_byte(input logic [7:0] b, input logic first, input logic last);
        logic [2:0]  st;
        logic        has_st;
        logic        at_data;
        logic [31:0] dsize;
        wav_result_t r;
        st      = ST_OK;
        has_st  = 1'b0;
        at_data = 1'b0;
        dsize   = '0;
        if (first) begin
            parse_ph  = PH_HEADER;
            pos       = '0;
            fcnt      = '0;
            tag       = '0;
            clen      = '0;
            skip_left = '0;
            fmt_lo    = '0;
            fmt_hi    = '0;
            fmt_ok    = 1'b0;
        end
        if (parse_ph == PH_IDLE || parse_ph == PH_DONE) return;
        parsed_bytes++;

        case (parse_ph)
            PH_HEADER: begin
                tag = {tag[23:0], b};
                // a wrong RIFF id is remembered until the WAVE id is in
                if (fcnt == 4'd3 && tag != TAG_RIFF) clen = 32'd1;
                if (fcnt >= 4'd11) begin
                    if (clen != 0 || tag != TAG_WAVE) begin
                        has_st = 1'b1;
                        st     = ST_BAD_MAGIC;
                    end else begin
                        parse_ph = PH_CHUNK;
                    end
                    fcnt = '0;
                end else begin
                    fcnt++;
                end
            end
            PH_CHUNK: begin
                // id big-endian, size little-endian
                if (fcnt < 4'd4) tag = {tag[23:0], b};
                else             clen = {b, clen[31:8]};
                if (fcnt >= 4'd7) begin
                    fcnt = '0;
                    if (tag == TAG_DATA) begin
                        has_st  = 1'b1;
                        at_data = 1'b1;
                        dsize   = clen;
                        st = (fmt_ok && fmt_lo[15:0] == FMT_PCM) ? ST_OK : ST_NOT_PCM;
                    end else if (tag == TAG_FMT) begin
                        if (clen < FMT_MIN_LEN) begin
                            has_st = 1'b1;
                            st     = ST_SHORT_FMT;
                        end else begin
                            skip_left = {1'b0, clen} - {1'b0, FMT_MIN_LEN} + {32'd0, clen[0]};
                            fmt_lo    = '0;
                            fmt_hi    = '0;
                            parse_ph  = PH_FMT;
                        end
                    end else begin
                        skip_left = {1'b0, clen} + {32'd0, clen[0]};
                        if (skip_left != 0) parse_ph = PH_SKIP;
                    end
                end else begin
                    fcnt++;
                end
            end
            PH_FMT: begin
                if (fcnt[3]) fmt_hi = fmt_hi | (64'(b) << (8 * fcnt[2:0]));
                else         fmt_lo = fmt_lo | (64'(b) << (8 * fcnt[2:0]));
                if (fcnt >= 4'd15) begin
                    fmt_ok   = 1'b1;
                    fcnt     = '0;
                    parse_ph = (skip_left != 0) ? PH_SKIP : PH_CHUNK;
                end else begin
                    fcnt++;
                end
            end
            default: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) begin
                    fcnt     = '0;
                    parse_ph = PH_CHUNK;
                end
            end
        endcase

        pos = pos + 32'd1;
        if (!has_st && last) begin
            has_st = 1'b1;
            st     = ST_TRUNC;
        end
        if (!has_st) return;

        parse_ph      = PH_DONE;
        r.status      = st;
        r.rate_hz     = '0;
        r.sample_bits = '0;
        r.channels    = '0;
        r.data_start  = '0;
        r.data_len    = '0;
        if (at_data) begin
            if (fmt_ok) begin
                r.rate_hz     = fmt_lo[63:32];
                r.sample_bits = fmt_hi[63:48];
                r.channels    = fmt_lo[31:16];
            end
            r.data_start = pos;
            r.data_len   = dsize;
        end
        pending_results.push_back(r);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    task automatic check_result(input logic [TDATA_W-1:0] word);
        wav_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, word);
            n_errors++;
            return;
        end
        want = pending_results.pop_front();
        cmp_field("status",      32'(want.status),      32'(word[2:0]));
        cmp_field("rate_hz",     want.rate_hz,          word[34:3]);
        cmp_field("sample_bits", 32'(want.sample_bits), 32'(word[50:35]));
        cmp_field("channels",    32'(want.channels),    32'(word[66:51]));
        cmp_field("data_start",  want.data_start,       word[98:67]);
        cmp_field("data_len",    want.data_len,         word[130:99]);
    endtask

    // Input side: every accepted byte goes through the model
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready === 1'b1)
            track_header_byte(s_tdata, s_tuser, s_tlast);
    end

    // Output side: every accepted result is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            check_result(m_tdata);
    end

    // Receiver: random gap after each result while rx_idle_on is set, plus a long hold-off on request
    always @(posedge aclk) begin
        if (stall_req != stall_ack) begin
            stall_ack = stall_req;
            rx_hold   = LONG_STALL;
        end
        if (m_tvalid === 1'b1 && m_tready)
            rx_gap = rx_idle_on ? $urandom_range(0, 10) : 0;
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // One byte transfer, after a random gap while tx_idle_on is set
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
    endtask

    task automatic send_file(input bit mark_last);
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0, mark_last && i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // Sender stays quiet until every expected result is out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_results.size() != 0);
    endtask

    // File building
    task automatic add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic add_tag(input logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
    endtask

    task automatic add_fill(input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_riff();
        add_tag(TAG_RIFF);
        add_le($urandom, 4);
        add_tag(TAG_WAVE);
    endtask

    task automatic add_fmt(input logic [31:0] len, input logic [15:0] code,
                           input logic [15:0] ch, input logic [31:0] rate,
                           input logic [15:0] bps);
        add_tag(TAG_FMT);
        add_le(len, 4);
        if (len >= FMT_MIN_LEN) begin
            add_le(32'(code), 2);
            add_le(32'(ch), 2);
            add_le(rate, 4);
            add_le($urandom, 4);   // byte rate, not kept
            add_le($urandom, 2);   // block align, not kept
            add_le(32'(bps), 2);
            add_fill(int'(len - FMT_MIN_LEN) + int'(len[0]));
        end
    endtask

    task automatic add_chunk(input logic [31:0] id, input int len);
        add_tag(id);
        add_le(32'(len), 4);
        add_fill(len + (len % 2));
    endtask

    task automatic add_data(input logic [31:0] size, input int trailing);
        add_tag(TAG_DATA);
        add_le(size, 4);
        add_fill(trailing);
    endtask

    task automatic add_random_fmt();
        logic [31:0] len;
        logic [15:0] code;
        logic [15:0] ch;
        len  = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(17, 24)) : FMT_MIN_LEN;
        code = ($urandom_range(0, 5) == 0) ? 16'($urandom) : FMT_PCM;
        ch   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
        add_fmt(len, code, ch, $urandom, 16'($urandom));
    endtask

    task automatic add_junk();
        logic [31:0] id;
        int len;
        case ($urandom_range(0, 2))
            0:       id = TAG_LIST;
            1:       id = TAG_FACT;
            default: id = $urandom;
        endcase
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
        add_chunk(id, len);
    endtask

    task automatic build_wav(input int kind);
        add_riff();
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_junk();
        if (kind == WAV_SHORT_FMT) begin
            add_fmt(32'($urandom_range(0, 15)), FMT_PCM, 16'd2, 32'd48000, 16'd16);
            add_fill($urandom_range(0, 4));
            return;
        end
        if (kind == WAV_GOOD) begin
            add_random_fmt();
            if ($urandom_range(0, 4) == 0) add_junk();
            if ($urandom_range(0, 4) == 0) add_random_fmt();
        end
        add_data($urandom, $urandom_range(0, 3));
    endtask

    // Bytes that arrive with no file open are dropped
    task automatic test_idle_bytes();
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h52, 1'b0, 1'b1);
    endtask

    // Well-formed files with field extremes, PCM and not
    task automatic test_format_fields();
        add_riff();
        add_fmt(FMT_MIN_LEN, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_data(32'hFFFF_FFFF, 2);
        send_file(1'b1);
        add_riff();
        add_fmt(FMT_MIN_LEN, FMT_PCM, 16'h0000, 32'h0000_0000, 16'h0000);
        add_data(32'h0000_0000, 0);
        send_file(1'b0);
        add_riff();
        add_fmt(FMT_MIN_LEN, 16'hFFFF, 16'd2, 32'd44100, 16'd24);
        add_data(32'd1000, 1);
        send_file(1'b1);
        add_riff();
        add_fmt(FMT_MIN_LEN, 16'h0000, 16'd1, 32'd8000, 16'd8);
        add_data(32'd7, 3);
        send_file(1'b0);
    endtask

    // Wrong RIFF id, wrong WAVE id, and a bad id cut short
    task automatic test_bad_magic();
        add_riff();
        file_bytes[0] = 8'h72;
        add_fill(6);
        send_file(1'b0);
        add_riff();
        file_bytes[11] = file_bytes[11] ^ 8'h01;
        add_fill(3);
        send_file(1'b1);
        add_tag(32'h5249_4658);
        add_fill(2);
        send_file(1'b1);
    endtask

    // Stream ends before or on the last byte of the data header
    task automatic test_truncation();
        // single byte that is both first and last
        send_byte(8'h52, 1'b1, 1'b1);
        // ends inside a chunk header
        add_riff();
        add_tag(TAG_FMT);
        add_fill(2);
        send_file(1'b1);
        // ends inside a huge chunk body
        add_riff();
        add_tag(TAG_LIST);
        add_le(32'hFFFF_FFFF, 4);
        add_fill(10);
        send_file(1'b1);
        // huge fmt: body read, then ends inside the remainder
        add_riff();
        add_tag(TAG_FMT);
        add_le(32'hFFFF_FFFE, 4);
        add_le(32'(FMT_PCM), 2);
        add_fill(19);
        send_file(1'b1);
        // last flag on the final data header byte: the data result wins
        add_riff();
        add_fmt(FMT_MIN_LEN, FMT_PCM, 16'd2, 32'd96000, 16'd32);
        add_data(32'h8000_0001, 0);
        send_file(1'b1);
    endtask

    // fmt chunk variants: short, missing, repeated, padded
    task automatic test_fmt_cases();
        add_riff();
        add_fmt(32'd15, FMT_PCM, 16'd2, 32'd48000, 16'd16);
        add_fill(5);
        send_file(1'b1);
        add_riff();
        add_fmt(32'd0, FMT_PCM, 16'd2, 32'd48000, 16'd16);
        send_file(1'b0);
        // data before any fmt
        add_riff();
        add_chunk(TAG_LIST, 3);
        add_data(32'd512, 1);
        send_file(1'b0);
        // second fmt replaces the first
        add_riff();
        add_fmt(FMT_MIN_LEN, 16'h0003, 16'd6, 32'd22050, 16'd12);
        add_chunk(TAG_FACT, 0);
        add_fmt(32'd17, FMT_PCM, 16'd1, 32'd11025, 16'd8);
        add_data(32'd64, 2);
        send_file(1'b1);
        // odd junk needs its pad byte skipped
        add_riff();
        add_fmt(32'd18, FMT_PCM, 16'd2, 32'd32000, 16'd16);
        add_chunk(TAG_LIST, 5);
        add_data(32'd3, 0);
        send_file(1'b0);
    endtask

    // A first byte mid-file restarts the parse
    task automatic test_restart();
        add_riff();
        add_fmt(FMT_MIN_LEN, FMT_PCM, 16'd2, 32'd48000, 16'd16);
        repeat (10) void'(file_bytes.pop_back());
        send_file(1'b0);
        build_wav(WAV_GOOD);
        send_file(1'b1);
    endtask

    // Receiver holds off while the sender keeps going, so the input stalls
    task automatic test_backpressure();
        stall_req <= stall_req + 1;
        tx_idle_on = 1'b0;
        repeat (5) begin
            build_wav(WAV_GOOD);
            send_file(1'b0);
        end
        tx_idle_on = 1'b1;
    endtask

    // Sender pauses until all results are out between files
    task automatic test_drain_pause();
        repeat (2) begin
            build_wav(WAV_GOOD);
            send_file(1'b1);
            wait_drain();
        end
    endtask

    // Mostly well-formed files with random content, some broken, some noise
    task automatic test_random();
        int byte_base;
        int kind;
        int cut;
        int idx;
        byte_base = parsed_bytes;
        while (parsed_bytes - byte_base < RANDOM_BYTES) begin
            kind       = $urandom_range(0, 19);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on <= ($urandom_range(0, 3) != 0);
            if (kind < 12) begin
                build_wav(WAV_GOOD);
                send_file($urandom_range(0, 1));
            end else if (kind < 14) begin
                build_wav(WAV_GOOD);
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
                send_file($urandom_range(0, 1));
            end else if (kind == 14) begin
                build_wav(WAV_GOOD);
                idx = $urandom_range(0, 7);
                if (idx >= 4) idx = idx + 4;
                file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
                send_file($urandom_range(0, 1));
            end else if (kind == 15) begin
                build_wav(WAV_SHORT_FMT);
                send_file($urandom_range(0, 1));
            end else if (kind == 16) begin
                build_wav(WAV_NO_FMT);
                send_file($urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                              $urandom_range(0, 3) == 0);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_bytes();
        test_format_fields();
        test_bad_magic();
        test_truncation();
        test_fmt_cases();
        test_restart();
        test_backpressure();
        test_drain_pause();
        test_random();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/whp_pkg.sv
rtl/core/wav_header_parser.sv
test/tb.sv
